[rtl/core/mqbe_pkg.sv]
// Shared constants and types for the median quantisation bit extractor.
package mqbe_pkg;

   localparam int STRENGTH_BITS = 16;
   localparam int STRENGTH_FRAC = 12;
   localparam logic [STRENGTH_BITS-1:0] STRENGTH_RESET = 16'd205;

   localparam int STATUS_BITS = 2;
   localparam logic [STATUS_BITS-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_STEP = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_OVF  = 2'd2;

   localparam int QPTR_BITS   = 3;
   localparam int QCNT_BITS   = QPTR_BITS + 1;
   localparam int QUEUE_DEPTH = 1 << QPTR_BITS;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic REG_STRENGTH = 1'b0;

   localparam int FRONT_STAGES = 5;

   typedef struct packed {
      logic not_empty;
      logic has_credit;
   } qstat_type;

endpackage

[rtl/core/mqbe_front.sv]
// Front end: sorts the window, classifies the step and forms numerator and denominator.
module mqbe_front
   import mqbe_pkg::*;
#(
   parameter int COEF_BITS = 24
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      in_valid,
   input  logic signed [COEF_BITS-1:0]               coef_a,
   input  logic signed [COEF_BITS-1:0]               coef_b,
   input  logic signed [COEF_BITS-1:0]               coef_c,
   input  logic [STRENGTH_BITS-1:0]                  strength,
   output logic                                      push,
   output logic [2*(COEF_BITS+17)+STATUS_BITS-1:0]   entry
);

   localparam int NUM_W = COEF_BITS + 17;
   localparam int SE_W  = STRENGTH_BITS + COEF_BITS;

   logic [FRONT_STAGES-1:0] vld_ff, vld_in;

   logic signed [COEF_BITS-1:0] lo_ff, mid_ff, hi_ff;
   logic signed [COEF_BITS-1:0] lo_in, mid_in, hi_in;

   logic [COEF_BITS-1:0] abs_lo_ff, abs_hi_ff, d1_ff;
   logic [COEF_BITS-1:0] abs_lo_in, abs_hi_in, d1_in;

   logic [COEF_BITS-1:0] emag_ff, d2_ff, emag_in;
   logic                 bad2_ff, bad2_in;

   logic [SE_W-1:0]      se_ff, se_in;
   logic [COEF_BITS-1:0] d3_ff;
   logic                 bad3_ff;

   logic [NUM_W-1:0]       num_ff, den_ff, num_in, den_in;
   logic [STATUS_BITS-1:0] st_ff, st_in;

   logic [COEF_BITS:0] e_diff;

   always_comb begin
      logic signed [COEF_BITS-1:0] t_lo, t_mid, t_hi, t;
      t_lo  = coef_a;
      t_mid = coef_b;
      t_hi  = coef_c;
      t     = t_lo;
      if (t_lo > t_mid) begin
         t     = t_lo;
         t_lo  = t_mid;
         t_mid = t;
      end
      if (t_mid > t_hi) begin
         t     = t_mid;
         t_mid = t_hi;
         t_hi  = t;
      end
      if (t_lo > t_mid) begin
         t     = t_lo;
         t_lo  = t_mid;
         t_mid = t;
      end
      lo_in  = t_lo;
      mid_in = t_mid;
      hi_in  = t_hi;
   end

   assign abs_lo_in = lo_ff[COEF_BITS-1] ? (~lo_ff + 1'b1) : lo_ff;
   assign abs_hi_in = hi_ff[COEF_BITS-1] ? (~hi_ff + 1'b1) : hi_ff;
   assign d1_in     = mid_ff - lo_ff;

   assign e_diff  = {1'b0, abs_hi_ff} - {1'b0, abs_lo_ff};
   assign emag_in = e_diff[COEF_BITS-1:0];
   assign bad2_in = e_diff[COEF_BITS] || (e_diff == '0) || (strength == '0);

   assign se_in = strength * emag_ff;

   assign num_in = (NUM_W'(d3_ff) << (STRENGTH_FRAC + 2)) + NUM_W'(se_ff);
   assign den_in = NUM_W'(se_ff) << 1;
   assign st_in  = bad3_ff ? STATUS_STEP : STATUS_OK;

   assign vld_in = {vld_ff[FRONT_STAGES-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff     <= lo_in;
      mid_ff    <= mid_in;
      hi_ff     <= hi_in;
      abs_lo_ff <= abs_lo_in;
      abs_hi_ff <= abs_hi_in;
      d1_ff     <= d1_in;
      emag_ff   <= emag_in;
      bad2_ff   <= bad2_in;
      d2_ff     <= d1_ff;
      se_ff     <= se_in;
      bad3_ff   <= bad2_ff;
      d3_ff     <= d2_ff;
      num_ff    <= num_in;
      den_ff    <= den_in;
      st_ff     <= st_in;
   end

   assign push  = vld_ff[FRONT_STAGES-1];
   assign entry = {st_ff, den_ff, num_ff};

endmodule

[rtl/core/mqbe_queue.sv]
// Short queue between front and back, with credits reserved at input acceptance.
module mqbe_queue
   import mqbe_pkg::*;
#(
   parameter int WIDTH = 84
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             reserve,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output qstat_type        qstat
);

   logic [WIDTH-1:0]     slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in, credit_ff, credit_in;

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
      credit_in = credit_ff;
      case ({reserve, pop})
         2'b10:   credit_in = credit_ff + 1'b1;
         2'b01:   credit_in = credit_ff - 1'b1;
         default: credit_in = credit_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         credit_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         credit_ff <= credit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data        = slot_ff[rd_ptr_ff];
   assign qstat.not_empty  = (count_ff != '0);
   assign qstat.has_credit = (credit_ff != QCNT_BITS'(QUEUE_DEPTH));

endmodule

[rtl/core/mqbe_back.sv]
// Back end: pipelined restoring divider giving quotient parity, and output register.
module mqbe_back
   import mqbe_pkg::*;
#(
   parameter int COEF_BITS = 24,
   parameter int QUOT_BITS = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  qstat_type                               qstat,
   input  logic [2*(COEF_BITS+17)+STATUS_BITS-1:0] head_data,
   output logic                                    pop,
   output logic                                    out_valid,
   input  logic                                    out_ready,
   output logic                                    out_bit,
   output logic [STATUS_BITS-1:0]                  out_status
);

   localparam int NUM_W = COEF_BITS + 17;

   logic [NUM_W-1:0]       rem_ff [QUOT_BITS];
   logic [NUM_W-1:0]       rem_in [QUOT_BITS];
   logic [NUM_W-1:0]       den_ff [QUOT_BITS];
   logic [NUM_W-1:0]       den_in [QUOT_BITS];
   logic [STATUS_BITS-1:0] st_ff  [QUOT_BITS];
   logic [STATUS_BITS-1:0] st_in  [QUOT_BITS];
   logic [QUOT_BITS-1:0]   vld_ff, vld_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_bit_ff, rsp_bit_in;
   logic [STATUS_BITS-1:0] rsp_st_ff, rsp_st_in;

   logic [NUM_W-1:0]       q_num, q_den, q_high;
   logic [STATUS_BITS-1:0] q_st;
   logic                   advance;

   assign advance = !rsp_valid_ff || out_ready;
   assign pop     = advance && qstat.not_empty;

   assign {q_st, q_den, q_num} = head_data;
   assign q_high = q_num >> QUOT_BITS;

   // Stage 0: quotient range check
   assign rem_in[0] = q_num;
   assign den_in[0] = q_den;
   assign st_in[0]  = ((q_st == STATUS_OK) && (q_high >= q_den)) ? STATUS_OVF : q_st;

   for (genvar j = 1; j < QUOT_BITS; j++) begin : g_div
      logic [NUM_W-1:0] den_sh, rem_sh;
      assign den_sh = den_ff[j-1] << (QUOT_BITS - j);
      assign rem_sh = rem_ff[j-1] >> (QUOT_BITS - j);
      assign den_in[j] = den_ff[j-1];
      assign st_in[j]  = st_ff[j-1];
      assign rem_in[j] = (rem_sh >= den_ff[j-1]) ? (rem_ff[j-1] - den_sh) : rem_ff[j-1];
   end

   for (genvar j = 0; j < QUOT_BITS; j++) begin : g_stage
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[j] <= rem_in[j];
            den_ff[j] <= den_in[j];
            st_ff[j]  <= st_in[j];
         end
      end
   end

   assign vld_in = {vld_ff[QUOT_BITS-2:0], qstat.not_empty};

   assign rsp_valid_in = vld_ff[QUOT_BITS-1];
   assign rsp_st_in    = st_ff[QUOT_BITS-1];
   assign rsp_bit_in   = (st_ff[QUOT_BITS-1] == STATUS_OK)
                         && (rem_ff[QUOT_BITS-1] >= den_ff[QUOT_BITS-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_bit_ff <= rsp_bit_in;
         rsp_st_ff  <= rsp_st_in;
      end
   end

   assign out_valid  = rsp_valid_ff;
   assign out_bit    = rsp_bit_ff;
   assign out_status = rsp_st_ff;

endmodule

[rtl/core/median_quantization_bit_extract.sv]
// Top level: stream ports, strength register and the front, queue and back parts.
//
// Takes one window of three coefficients per cycle while queue credit is left (req_tready)
// and returns one transaction per window: the parity of the nearest quantisation index of
// the middle value, with a status code. Sustained rate is one window per clock while
// results are taken. The path runs through the five-stage sort and multiply front end,
// the queue, the QUOT_BITS-stage divider and the output register.
// The input side keeps accepting while results wait, up to eight windows held in flight
// between input and divider.
module median_quantization_bit_extract
   import mqbe_pkg::*;
#(
   parameter int COEF_BITS = 24,
   parameter int QUOT_BITS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // req_tdata: coef_a, coef_b, coef_c
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((3*COEF_BITS+7)/8)*8-1:0]       req_tdata,
   // rsp_tdata: extracted_bit
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [7:0]                             rsp_tdata,
   // rsp_tuser: status
   output logic [STATUS_BITS-1:0]                 rsp_tuser,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]               csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]               csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]               csr_prdata,
   output logic                                   csr_pready
);

   localparam int ENTRY_BITS = 2*(COEF_BITS+17) + STATUS_BITS;

   logic [STRENGTH_BITS-1:0] strength_ff, strength_in;
   logic                     csr_write;
   logic                     req_accept;
   logic                     push, pop;
   logic [ENTRY_BITS-1:0]    push_data, head_data;
   qstat_type                qstat;
   logic                     out_bit;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[CSR_ADDR_BITS-1:2] == REG_STRENGTH);
   assign strength_in = csr_write ? csr_pwdata[STRENGTH_BITS-1:0] : strength_ff;
   assign csr_prdata  = (csr_paddr[CSR_ADDR_BITS-1:2] == REG_STRENGTH)
                        ? CSR_DATA_BITS'(strength_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         strength_ff <= STRENGTH_RESET;
      end else begin
         strength_ff <= strength_in;
      end
   end

   assign req_tready = qstat.has_credit;
   assign req_accept = req_tvalid && req_tready;

   mqbe_front #(
      .COEF_BITS (COEF_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_accept),
      .coef_a   (req_tdata[COEF_BITS-1:0]),
      .coef_b   (req_tdata[2*COEF_BITS-1:COEF_BITS]),
      .coef_c   (req_tdata[3*COEF_BITS-1:2*COEF_BITS]),
      .strength (strength_ff),
      .push     (push),
      .entry    (push_data)
   );

   mqbe_queue #(
      .WIDTH (ENTRY_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .reserve   (req_accept),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .qstat     (qstat)
   );

   mqbe_back #(
      .COEF_BITS (COEF_BITS),
      .QUOT_BITS (QUOT_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .qstat      (qstat),
      .head_data  (head_data),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_bit    (out_bit),
      .out_status (rsp_tuser)
   );

   assign rsp_tdata = {7'b0, out_bit};

endmodule
